### sv/owb_pkg.sv
// shared types and constants of the one-wire bus master
package owb_pkg;

    // released ticks after a reset pulse measurement and after each write slot
    localparam int RECOVERY_TICKS = 5;

    // widths of the transaction fields
    localparam int MODE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 11;
    localparam int LONG_W  = 10;
    localparam int SHORT_W = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // command codes of the mode field
    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RESET = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POLL  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW   = 3'd0;
    localparam logic [2:0] REG_RESP_TMO    = 3'd1;
    localparam logic [2:0] REG_PRES_MIN    = 3'd2;
    localparam logic [2:0] REG_PRES_MAX    = 3'd3;
    localparam logic [2:0] REG_WRITE_ZERO  = 3'd4;
    localparam logic [2:0] REG_SHORT_LOW   = 3'd5;
    localparam logic [2:0] REG_SAMPLE_PT   = 3'd6;
    localparam logic [2:0] REG_SLOT_LEN    = 3'd7;

    // timing configuration seen by the bus sequencer
    typedef struct packed {
        logic [LONG_W-1:0]  reset_low_time;
        logic [LONG_W-1:0]  response_timeout;
        logic [LONG_W-1:0]  presence_min;
        logic [LONG_W-1:0]  presence_max;
        logic [SHORT_W-1:0] write_zero_low;
        logic [SHORT_W-1:0] short_low;
        logic [SHORT_W-1:0] sample_point;
        logic [SHORT_W-1:0] slot_length;
    } t_cfg;

endpackage

### sv/owb_if.sv
// valid/ready channel interfaces for ticks in and results out

interface owb_in_if;
    import owb_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic              line_level;

    modport source (output valid, output mode, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_level,
                    output ready);
endinterface

interface owb_out_if;
    import owb_pkg::*;

    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] read_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_byte, output ready);
endinterface

### sv/owb_regs.sv
// apb register file holding the bus timing configuration
module owb_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [owb_pkg::ADDR_W-1:0] paddr,
    input  logic [owb_pkg::DATA_W-1:0] pwdata,
    output logic [owb_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output owb_pkg::t_cfg             o_cfg
);
    import owb_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time   <= 10'd480;
            r_cfg.response_timeout <= 10'd60;
            r_cfg.presence_min     <= 10'd60;
            r_cfg.presence_max     <= 10'd240;
            r_cfg.write_zero_low   <= 8'd60;
            r_cfg.short_low        <= 8'd6;
            r_cfg.sample_point     <= 8'd15;
            r_cfg.slot_length      <= 8'd60;
        end else if (w_wr) begin
            case (w_idx)
                REG_RESET_LOW:  r_cfg.reset_low_time   <= pwdata[LONG_W-1:0];
                REG_RESP_TMO:   r_cfg.response_timeout <= pwdata[LONG_W-1:0];
                REG_PRES_MIN:   r_cfg.presence_min     <= pwdata[LONG_W-1:0];
                REG_PRES_MAX:   r_cfg.presence_max     <= pwdata[LONG_W-1:0];
                REG_WRITE_ZERO: r_cfg.write_zero_low   <= pwdata[SHORT_W-1:0];
                REG_SHORT_LOW:  r_cfg.short_low        <= pwdata[SHORT_W-1:0];
                REG_SAMPLE_PT:  r_cfg.sample_point     <= pwdata[SHORT_W-1:0];
                REG_SLOT_LEN:   r_cfg.slot_length      <= pwdata[SHORT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_RESET_LOW:  prdata = DATA_W'(r_cfg.reset_low_time);
            REG_RESP_TMO:   prdata = DATA_W'(r_cfg.response_timeout);
            REG_PRES_MIN:   prdata = DATA_W'(r_cfg.presence_min);
            REG_PRES_MAX:   prdata = DATA_W'(r_cfg.presence_max);
            REG_WRITE_ZERO: prdata = DATA_W'(r_cfg.write_zero_low);
            REG_SHORT_LOW:  prdata = DATA_W'(r_cfg.short_low);
            REG_SAMPLE_PT:  prdata = DATA_W'(r_cfg.sample_point);
            REG_SLOT_LEN:   prdata = DATA_W'(r_cfg.slot_length);
            default:        prdata = '0;
        endcase
    end

endmodule

### sv/one_wire_bus_master.sv
// one-wire bus master: each tick transaction advances the sequencer one step
// the result of a tick is registered and shown in the cycle after its transaction is taken
// throughput: one tick per cycle, set by the single-step sequencer update between input and
// result register; a tick is taken in the cycle the waiting result leaves, a stalled result
// holds the input
// reset: synchronous active low; sequencer idle, counters, presence and read byte cleared,
// timing registers back to their defaults
module one_wire_bus_master (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    owb_in_if.sink                     i_in,
    owb_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owb_pkg::ADDR_W-1:0] paddr,
    input  logic [owb_pkg::DATA_W-1:0] pwdata,
    output logic [owb_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import owb_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_RST_LOW  = 7'b0000010,
        PH_RST_WAIT = 7'b0000100,
        PH_RST_MEAS = 7'b0001000,
        PH_RST_REC  = 7'b0010000,
        PH_WSLOT    = 7'b0100000,
        PH_RSLOT    = 7'b1000000
    } t_phase;

    t_cfg               w_cfg;
    logic               w_acc;

    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [2:0]         r_bit, n_bit;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic               r_pres, n_pres;
    logic [MODE_W-1:0]  r_kind, n_kind;
    logic [BYTE_W-1:0]  r_last, n_last;

    logic               r_out_valid;
    logic               r_drive, n_drive;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    // slot arithmetic
    logic               v_bitval;
    logic [SHORT_W-1:0] v_low;
    logic [SHORT_W-1:0] v_wlen;
    logic [TICK_W-1:0]  v_wslot;
    logic [SHORT_W-1:0] v_smax;
    logic [SHORT_W:0]   v_samp;
    logic [SHORT_W:0]   v_rslot;
    logic               v_finish;

    owb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // take a tick whenever the output register is free or being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    // one sequencer step per tick
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_pres   = r_pres;
        n_kind   = r_kind;
        n_last   = r_last;
        n_drive  = 1'b0;
        v_finish = 1'b0;

        // command start on an idle tick
        if (r_phase == PH_IDLE && (i_in.mode == MODE_RESET || i_in.mode == MODE_WRITE ||
                                   i_in.mode == MODE_READ  || i_in.mode == MODE_POLL)) begin
            n_kind = i_in.mode;
            n_tick = '0;
            n_bit  = '0;
            if (i_in.mode == MODE_RESET) begin
                n_phase = PH_RST_LOW;
            end else if (i_in.mode == MODE_WRITE) begin
                n_shift = i_in.data_byte;
                n_phase = PH_WSLOT;
            end else begin
                n_shift = '0;
                n_phase = PH_RSLOT;
            end
        end

        v_bitval = n_shift[n_bit];
        v_low    = v_bitval ? w_cfg.short_low : w_cfg.write_zero_low;
        v_wlen   = (w_cfg.write_zero_low > v_low) ? w_cfg.write_zero_low : v_low;
        v_wslot  = {3'b000, v_wlen} + TICK_W'(RECOVERY_TICKS);
        v_smax   = (w_cfg.sample_point > w_cfg.short_low) ? w_cfg.sample_point
                                                           : w_cfg.short_low;
        v_samp   = {1'b0, v_smax} + 9'd1;
        v_rslot  = ({1'b0, w_cfg.slot_length} > v_samp) ? {1'b0, w_cfg.slot_length} : v_samp;

        case (n_phase)
            PH_IDLE: ;
            // master holds the line low
            PH_RST_LOW: begin
                n_drive = 1'b1;
                n_tick  = n_tick + 1'b1;
                if (n_tick >= {1'b0, w_cfg.reset_low_time}) begin
                    n_phase = PH_RST_WAIT;
                    n_tick  = '0;
                end
            end
            // wait for the device to answer low
            PH_RST_WAIT: begin
                if (i_in.line_level) begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= {1'b0, w_cfg.response_timeout}) begin
                        n_pres   = 1'b0;
                        v_finish = 1'b1;
                    end
                end else begin
                    n_phase = PH_RST_MEAS;
                    n_tick  = TICK_W'(1);
                    if (n_tick >= {1'b0, w_cfg.presence_max}) begin
                        n_pres   = 1'b0;
                        v_finish = 1'b1;
                    end
                end
            end
            // measure the presence pulse
            PH_RST_MEAS: begin
                if (!i_in.line_level) begin
                    n_tick = n_tick + 1'b1;
                    if (n_tick >= {1'b0, w_cfg.presence_max}) begin
                        n_pres   = 1'b0;
                        v_finish = 1'b1;
                    end
                end else begin
                    n_pres  = (n_tick > {1'b0, w_cfg.presence_min}) &&
                              (n_tick < {1'b0, w_cfg.presence_max});
                    n_phase = PH_RST_REC;
                    n_tick  = TICK_W'(1);
                    if (n_tick >= TICK_W'(RECOVERY_TICKS)) begin
                        v_finish = 1'b1;
                    end
                end
            end
            PH_RST_REC: begin
                n_tick = n_tick + 1'b1;
                if (n_tick >= TICK_W'(RECOVERY_TICKS)) begin
                    v_finish = 1'b1;
                end
            end
            // write slot, lsb first
            PH_WSLOT: begin
                n_tick  = n_tick + 1'b1;
                n_drive = (n_tick <= {3'b000, v_low});
                if (n_tick >= v_wslot) begin
                    n_tick = '0;
                    if (n_bit == 3'd7) begin
                        v_finish = 1'b1;
                    end else begin
                        n_bit = n_bit + 1'b1;
                    end
                end
            end
            // read slot for read byte and poll
            PH_RSLOT: begin
                n_tick  = n_tick + 1'b1;
                n_drive = (n_tick <= {3'b000, w_cfg.short_low});
                if (n_tick == {2'b00, v_samp}) begin
                    if (n_kind == MODE_READ) begin
                        n_shift[n_bit] = n_shift[n_bit] | i_in.line_level;
                    end else begin
                        n_shift = {7'b0000000, i_in.line_level};
                    end
                end
                if (n_tick >= {2'b00, v_rslot}) begin
                    n_tick = '0;
                    if (n_kind == MODE_READ) begin
                        if (n_bit == 3'd7) begin
                            n_last   = n_shift;
                            v_finish = 1'b1;
                        end else begin
                            n_bit = n_bit + 1'b1;
                        end
                    end else begin
                        if (n_shift[0]) begin
                            v_finish = 1'b1;
                        end
                        n_shift = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_done = v_finish;
        if (v_finish) begin
            n_phase = PH_IDLE;
            n_tick  = '0;
        end
        n_busy = (n_phase != PH_IDLE);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_shift <= '0;
            r_pres  <= 1'b0;
            r_kind  <= MODE_NONE;
            r_last  <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_pres  <= n_pres;
            r_kind  <= n_kind;
            r_last  <= n_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_drive <= n_drive;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_drive;
    assign o_out.busy_res  = r_busy;
    assign o_out.done_res  = r_done;
    assign o_out.presence  = r_pres;
    assign o_out.read_byte = r_last;

`ifndef SYNTHESIS
    // the sequencer phase stays one-hot
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("sequencer phase not one-hot");

    // an idle tick with no command leaves the line released and the block idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_IDLE && (i_in.mode == MODE_NONE || i_in.mode > MODE_POLL))
        |=> (o_out.valid && !o_out.drive_low && !o_out.busy_res && !o_out.done_res &&
             r_phase == PH_IDLE))
        else $error("idle tick changed bus or state");

    // a completing tick returns the sequencer to idle with a cleared counter
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && n_done) |=> (r_phase == PH_IDLE && r_tick == '0 && !o_out.busy_res))
        else $error("command completion left sequencer busy");

    // the bus is never driven outside a command
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && n_drive) |=> (o_out.busy_res || o_out.done_res))
        else $error("line driven low while idle");
`endif

endmodule

### dv/one_wire_bus_master_checker.sv
// result checker for the one-wire bus master: tick predictor, expected results and compare
module one_wire_bus_master_checker
    import owb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    owb_in_if                 i_tick,
    owb_out_if                i_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_waiting
);

    // timing registers as they come out of reset
    localparam t_cfg TIMING_AT_RESET = '{10'd480, 10'd60, 10'd60, 10'd240,
                                         8'd60, 8'd6, 8'd15, 8'd60};

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_RST_MEAS,
        SEQ_RST_REC,
        SEQ_WSLOT,
        SEQ_RSLOT
    } seq_phase_e;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_byte;
    } tick_result_t;

    // predicted sequencer state and its own copy of the timing registers
    t_cfg              timing;
    seq_phase_e        seq_phase;
    int unsigned       tick_cnt;
    int unsigned       bit_idx;
    logic [BYTE_W-1:0] shift_reg;
    logic [BYTE_W-1:0] last_byte;
    logic              pres_flag;
    logic [MODE_W-1:0] cmd_kind;

    tick_result_t tick_results_q[$];
    int           mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int unsigned umax(input int unsigned a, input int unsigned b);
        return (a > b) ? a : b;
    endfunction

    // advance the sequencer by one tick and return what the block shows for it
    function automatic tick_result_t next_bus_tick(input logic [MODE_W-1:0] mode,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic line);
        int unsigned  low_len;
        int unsigned  slot_len;
        int unsigned  sample_at;
        logic         bit_val;
        logic         drive;
        logic         finish;
        tick_result_t r;
        drive  = 1'b0;
        finish = 1'b0;

        // a command only starts on an idle tick, and runs on that same tick
        if (seq_phase == SEQ_IDLE && mode >= MODE_RESET && mode <= MODE_POLL) begin
            cmd_kind = mode;
            tick_cnt = 0;
            bit_idx  = 0;
            if (mode == MODE_RESET) begin
                seq_phase = SEQ_RST_LOW;
            end else if (mode == MODE_WRITE) begin
                shift_reg = data;
                seq_phase = SEQ_WSLOT;
            end else begin
                shift_reg = '0;
                seq_phase = SEQ_RSLOT;
            end
        end

        case (seq_phase)
            SEQ_RST_LOW: begin
                drive = 1'b1;
                tick_cnt++;
                if (tick_cnt >= timing.reset_low_time) begin
                    seq_phase = SEQ_RST_WAIT;
                    tick_cnt  = 0;
                end
            end
            // wait for the device to pull low, or time out with no presence
            SEQ_RST_WAIT: begin
                if (line) begin
                    tick_cnt++;
                    if (tick_cnt >= timing.response_timeout) begin
                        pres_flag = 1'b0;
                        finish    = 1'b1;
                    end
                end else begin
                    seq_phase = SEQ_RST_MEAS;
                    tick_cnt  = 1;
                    if (tick_cnt >= timing.presence_max) begin
                        pres_flag = 1'b0;
                        finish    = 1'b1;
                    end
                end
            end
            // measure the presence pulse, judge it on the first high sample
            SEQ_RST_MEAS: begin
                if (!line) begin
                    tick_cnt++;
                    if (tick_cnt >= timing.presence_max) begin
                        pres_flag = 1'b0;
                        finish    = 1'b1;
                    end
                end else begin
                    pres_flag = (tick_cnt > timing.presence_min) &&
                                (tick_cnt < timing.presence_max);
                    seq_phase = SEQ_RST_REC;
                    tick_cnt  = 1;
                    if (tick_cnt >= RECOVERY_TICKS) finish = 1'b1;
                end
            end
            SEQ_RST_REC: begin
                tick_cnt++;
                if (tick_cnt >= RECOVERY_TICKS) finish = 1'b1;
            end
            // write slot, lsb first, recovery folded into the slot length
            SEQ_WSLOT: begin
                bit_val  = shift_reg[bit_idx[2:0]];
                low_len  = bit_val ? timing.short_low : timing.write_zero_low;
                slot_len = umax(timing.write_zero_low, low_len) + RECOVERY_TICKS;
                tick_cnt++;
                drive = (tick_cnt <= low_len);
                if (tick_cnt >= slot_len) begin
                    tick_cnt = 0;
                    if (bit_idx >= 7) finish = 1'b1;
                    else bit_idx++;
                end
            end
            // read slot, shared by byte read and poll
            SEQ_RSLOT: begin
                sample_at = umax(timing.sample_point, timing.short_low) + 1;
                slot_len  = umax(timing.slot_length, sample_at);
                tick_cnt++;
                drive = (tick_cnt <= timing.short_low);
                if (tick_cnt == sample_at) begin
                    if (cmd_kind == MODE_READ) begin
                        shift_reg[bit_idx[2:0]] = shift_reg[bit_idx[2:0]] | line;
                    end else begin
                        shift_reg = {{(BYTE_W-1){1'b0}}, line};
                    end
                end
                if (tick_cnt >= slot_len) begin
                    tick_cnt = 0;
                    if (cmd_kind == MODE_READ) begin
                        if (bit_idx >= 7) begin
                            last_byte = shift_reg;
                            finish    = 1'b1;
                        end else begin
                            bit_idx++;
                        end
                    end else begin
                        if (shift_reg[0]) finish = 1'b1;
                        shift_reg = '0;
                    end
                end
            end
            default: begin
                seq_phase = SEQ_IDLE;
            end
        endcase

        if (finish) begin
            seq_phase = SEQ_IDLE;
            tick_cnt  = 0;
        end

        r.drive_low = drive;
        r.busy_res  = (seq_phase != SEQ_IDLE);
        r.done_res  = finish;
        r.presence  = pres_flag;
        r.read_byte = last_byte;
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin : track
        tick_result_t want;
        if (!i_rst_n) begin
            timing    = TIMING_AT_RESET;
            seq_phase = SEQ_IDLE;
            tick_cnt  = 0;
            bit_idx   = 0;
            shift_reg = '0;
            last_byte = '0;
            pres_flag = 1'b0;
            cmd_kind  = MODE_NONE;
            tick_results_q.delete();
        end else begin
            // result transaction against the oldest expectation
            if (i_res.valid && i_res.ready) begin
                if (tick_results_q.size() == 0) begin
                    report_mismatch("result transaction with no tick waiting for it");
                end else begin
                    want = tick_results_q.pop_front();
                    if (i_res.drive_low !== want.drive_low)
                        report_mismatch($sformatf("drive_low got %0b want %0b",
                                                  i_res.drive_low, want.drive_low));
                    if (i_res.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res got %0b want %0b",
                                                  i_res.busy_res, want.busy_res));
                    if (i_res.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res got %0b want %0b",
                                                  i_res.done_res, want.done_res));
                    if (i_res.presence !== want.presence)
                        report_mismatch($sformatf("presence got %0b want %0b",
                                                  i_res.presence, want.presence));
                    if (i_res.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte got %02h want %02h",
                                                  i_res.read_byte, want.read_byte));
                end
            end
            // tick transaction
            if (i_tick.valid && i_tick.ready) begin
                tick_results_q.push_back(next_bus_tick(i_tick.mode, i_tick.data_byte,
                                                       i_tick.line_level));
            end
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_RESET_LOW:  timing.reset_low_time   = i_pwdata[LONG_W-1:0];
                    REG_RESP_TMO:   timing.response_timeout = i_pwdata[LONG_W-1:0];
                    REG_PRES_MIN:   timing.presence_min     = i_pwdata[LONG_W-1:0];
                    REG_PRES_MAX:   timing.presence_max     = i_pwdata[LONG_W-1:0];
                    REG_WRITE_ZERO: timing.write_zero_low   = i_pwdata[SHORT_W-1:0];
                    REG_SHORT_LOW:  timing.short_low        = i_pwdata[SHORT_W-1:0];
                    REG_SAMPLE_PT:  timing.sample_point     = i_pwdata[SHORT_W-1:0];
                    REG_SLOT_LEN:   timing.slot_length      = i_pwdata[SHORT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_waiting    <= tick_results_q.size();
    end

endmodule

### dv/one_wire_bus_master_tb.sv
// testbench top of the one-wire bus master: clock, reset, stimulus and verdict
module one_wire_bus_master_tb;
    import owb_pkg::*;

    localparam int   TIMEOUT_CYCLES = 4000;
    localparam int   HOLD_CYCLES    = 150;
    localparam int   RANDOM_TICKS   = 400;
    localparam int   SCRIPT_TICKS   = 1024;
    localparam int   END_CYCLES     = 10;
    localparam t_cfg RESET_CFG      = '{10'd480, 10'd60, 10'd60, 10'd240,
                                        8'd60, 8'd6, 8'd15, 8'd60};

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    owb_in_if  tick_ch();
    owb_out_if res_ch();

    int fail_count;
    int waiting;

    // stimulus state
    t_cfg              cur_cfg = RESET_CFG;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                noise_pct = 10;
    int                hold_ticket = 0;
    int                hold_served = 0;
    int                in_cnt = 0;
    int                done_cnt = 0;
    logic              last_busy = 1'b0;
    int                quiet_cycles = 0;

    // device behavior planned for the running command
    logic [MODE_W-1:0] script_mode;
    logic              script_noisy;
    int                read_fill;
    int                rst_end;
    int                wait_len;
    int                meas_len;

    one_wire_bus_master uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    one_wire_bus_master_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_res        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // transaction counts seen by the stimulus
    always @(posedge i_clk) begin
        if (tick_ch.valid && tick_ch.ready) in_cnt <= in_cnt + 1;
        if (res_ch.valid && res_ch.ready) begin
            last_busy <= res_ch.busy_res;
            if (res_ch.done_res) done_cnt <= done_cnt + 1;
        end
    end

    // result receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge i_clk);
        end
    end

    // watchdog on cycles with no transaction anywhere
    initial begin
        while (quiet_cycles < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("one_wire_bus_master: mismatch");
        $finish;
    end

    task automatic send_tick(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                             input logic line);
        while ($urandom_range(0, 99) < idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.mode       <= mode;
        tick_ch.data_byte  <= data;
        tick_ch.line_level <= line;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        reg_write(REG_RESET_LOW,  DATA_W'(c.reset_low_time));
        reg_write(REG_RESP_TMO,   DATA_W'(c.response_timeout));
        reg_write(REG_PRES_MIN,   DATA_W'(c.presence_min));
        reg_write(REG_PRES_MAX,   DATA_W'(c.presence_max));
        reg_write(REG_WRITE_ZERO, DATA_W'(c.write_zero_low));
        reg_write(REG_SHORT_LOW,  DATA_W'(c.short_low));
        reg_write(REG_SAMPLE_PT,  DATA_W'(c.sample_point));
        reg_write(REG_SLOT_LEN,   DATA_W'(c.slot_length));
        cur_cfg = c;
    endtask

    // stop offering ticks and wait for every result to come back
    task automatic wait_quiet();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    // bring the sequencer back to idle with a released line, which ends every command
    task automatic settle_block();
        int done_before;
        wait_quiet();
        while (last_busy) begin
            done_before = done_cnt;
            while (done_cnt == done_before)
                send_tick(MODE_NONE, BYTE_W'($urandom), 1'b1);
            wait_quiet();
        end
    endtask

    // line level the emulated device shows on tick k of the command
    function automatic logic bus_level(input int k);
        // past any planned command the line is released, so a stray poll ends too
        if (k > SCRIPT_TICKS) return 1'b1;
        if (script_noisy) return 1'($urandom_range(0, 1));
        case (script_mode)
            MODE_RESET: begin
                if (k <= rst_end) return 1'($urandom_range(0, 1));
                if (k <= rst_end + wait_len) return 1'b1;
                if (k <= rst_end + wait_len + meas_len) return 1'b0;
                return 1'b1;
            end
            MODE_READ: begin
                if (read_fill == 0) return 1'b0;
                if (read_fill == 1) return 1'b1;
                return 1'($urandom_range(0, 1));
            end
            MODE_POLL: return ($urandom_range(0, 2) == 0);
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // one command plus filler ticks until its done transaction shows up
    task automatic run_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data);
        int done_before;
        int k;
        int pmin;
        int pmax;
        pmin         = cur_cfg.presence_min;
        pmax         = cur_cfg.presence_max;
        script_mode  = mode;
        script_noisy = ($urandom_range(0, 7) == 0);
        read_fill    = $urandom_range(0, 3);
        rst_end      = (cur_cfg.reset_low_time == 0) ? 1 : cur_cfg.reset_low_time;
        wait_len     = $urandom_range(0, cur_cfg.response_timeout + 1);
        // presence pulse lengths around both window edges
        case ($urandom_range(0, 4))
            0: meas_len = pmin;
            1: meas_len = pmin + 1;
            2: meas_len = (pmax > 1) ? pmax - 1 : 1;
            3: meas_len = pmax;
            default: meas_len = $urandom_range(1, pmax + 2);
        endcase
        done_before = done_cnt;
        k = 1;
        send_tick(mode, data, bus_level(k));
        while (done_cnt == done_before) begin
            k++;
            send_tick(($urandom_range(0, 99) < noise_pct) ? MODE_W'($urandom) : MODE_NONE,
                      BYTE_W'($urandom), bus_level(k));
        end
    endtask

    // main stimulus
    initial begin : stimulus
        t_cfg rand_cfg;
        int   group;
        int   random_base;
        i_rst_n            <= 1'b0;
        tick_ch.valid      <= 1'b0;
        tick_ch.mode       <= MODE_NONE;
        tick_ch.data_byte  <= '0;
        tick_ch.line_level <= 1'b1;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // timing registers at their reset values
        run_command(MODE_RESET, '0);
        run_command(MODE_POLL, '0);

        // all registers zero
        settle_block();
        apply_cfg('0);
        run_command(MODE_RESET, '0);
        run_command(MODE_WRITE, 8'h00);
        run_command(MODE_WRITE, 8'hFF);
        run_command(MODE_READ, '0);
        run_command(MODE_POLL, '0);
        // unknown modes and no-command ticks while idle
        for (int m = MODE_NONE; m < (1 << MODE_W); m++) begin
            if (m == MODE_NONE || m > MODE_POLL)
                send_tick(MODE_W'(m), 8'hFF, 1'b0);
        end

        // narrow presence window, lots of commands offered while busy
        settle_block();
        apply_cfg('{10'd8, 10'd6, 10'd3, 10'd9, 8'd6, 8'd2, 8'd3, 8'd7});
        noise_pct = 40;
        repeat (6) run_command(MODE_RESET, '0);
        run_command(MODE_WRITE, 8'h5A);
        run_command(MODE_READ, '0);
        run_command(MODE_POLL, '0);
        noise_pct = 10;

        // random part: small timings, idling pattern changes per group
        random_base = in_cnt;
        group = 0;
        while (group < 4 || in_cnt - random_base < RANDOM_TICKS) begin
            settle_block();
            rand_cfg.reset_low_time   = LONG_W'($urandom_range(0, 12));
            rand_cfg.response_timeout = LONG_W'($urandom_range(0, 12));
            rand_cfg.presence_min     = LONG_W'($urandom_range(0, 8));
            rand_cfg.presence_max     = LONG_W'($urandom_range(0, 16));
            rand_cfg.write_zero_low   = SHORT_W'($urandom_range(0, 10));
            rand_cfg.short_low        = SHORT_W'($urandom_range(0, 6));
            rand_cfg.sample_point     = SHORT_W'($urandom_range(0, 8));
            rand_cfg.slot_length      = SHORT_W'($urandom_range(0, 12));
            apply_cfg(rand_cfg);
            case (group % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            // long receiver hold-off so the block backs up into its input
            if (group % 4 == 0) hold_ticket++;
            repeat ($urandom_range(2, 4)) begin
                run_command(MODE_W'($urandom_range(MODE_RESET, MODE_POLL)),
                            BYTE_W'($urandom));
                // a few stray ticks between commands
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_tick(MODE_W'($urandom), BYTE_W'($urandom),
                                  1'($urandom_range(0, 1)));
            end
            group++;
        end

        settle_block();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("one_wire_bus_master: match");
        end else begin
            $display("one_wire_bus_master: mismatch");
        end
        $finish;
    end

endmodule

### one_wire_bus_master.f
sv/owb_pkg.sv
sv/owb_if.sv
sv/owb_regs.sv
sv/one_wire_bus_master.sv
dv/one_wire_bus_master_checker.sv
dv/one_wire_bus_master_tb.sv
